[rtl/core/tnqm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnqm_pkg
// Shared types and constants for the table-driven quadrature oscillator/mixer.
// ----------------------------------------------------------------------------
package tnqm_pkg;

	localparam logic [1:0] CMD_NEXT    = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;

	localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
	localparam logic [1:0] REG_MIX_MODE     = 2'd2;

	localparam logic [16:0] BLOCK_LENGTH_RESET = 17'd1024;
	localparam logic [16:0] BLOCK_LENGTH_MAX   = 17'd65536;

	localparam int WQ_DEPTH = 4;
	localparam int OQ_DEPTH = 8;
	localparam int OQ_CW    = $clog2(OQ_DEPTH) + 1;

	typedef struct packed {
		logic [31:0]        phase;
		logic               last;
		logic               mix;
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
	} work_t;

	typedef struct packed {
		logic signed [15:0] out_re;
		logic signed [15:0] out_im;
		logic               last;
	} res_t;

endpackage
`default_nettype wire

[rtl/core/tnqm_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnqm_fifo
// Small synchronous queue with occupancy count.
// ----------------------------------------------------------------------------
module tnqm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	output logic [WIDTH-1:0]         rd_data,
	output logic                     empty,
	output logic                     full,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (AW+1)'(DEPTH));
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (!do_wr && do_rd)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

[rtl/core/tnqm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnqm_front
// Command decode, configuration, phase accumulator and block counter.
// ----------------------------------------------------------------------------
module tnqm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          cmd,
	input  logic [31:0]         lookup_phase,
	input  logic signed [15:0]  sample_re,
	input  logic signed [15:0]  sample_im,
	input  logic                cfg_wr,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                wq_push,
	output tnqm_pkg::work_t     wq_item
);

	logic [31:0] phase_step_q;
	logic [16:0] block_length_q;
	logic        mix_mode_q;
	logic [31:0] phase_acc_q;
	logic [15:0] sample_count_q;
	logic [16:0] len_m1;
	logic        is_last;

	always_comb begin
		if (block_length_q == '0)
			len_m1 = '0;
		else if (block_length_q > tnqm_pkg::BLOCK_LENGTH_MAX)
			len_m1 = tnqm_pkg::BLOCK_LENGTH_MAX - 17'd1;
		else
			len_m1 = block_length_q - 17'd1;
	end

	assign is_last = ({1'b0, sample_count_q} == len_m1);

	assign wq_push = accept && (cmd == tnqm_pkg::CMD_NEXT || cmd == tnqm_pkg::CMD_LOOKUP);

	always_comb begin
		wq_item.phase     = (cmd == tnqm_pkg::CMD_LOOKUP) ? lookup_phase : phase_acc_q;
		wq_item.last      = (cmd == tnqm_pkg::CMD_NEXT) && is_last;
		wq_item.mix       = (cmd == tnqm_pkg::CMD_NEXT) && mix_mode_q;
		wq_item.sample_re = sample_re;
		wq_item.sample_im = sample_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			block_length_q <= tnqm_pkg::BLOCK_LENGTH_RESET;
			mix_mode_q     <= 1'b0;
			phase_acc_q    <= '0;
			sample_count_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					tnqm_pkg::REG_PHASE_STEP: begin
						phase_step_q <= cfg_data;
					end
					tnqm_pkg::REG_BLOCK_LENGTH: begin
						block_length_q <= cfg_data[16:0];
					end
					tnqm_pkg::REG_MIX_MODE: begin
						mix_mode_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				case (cmd)
					tnqm_pkg::CMD_NEXT: begin
						if (is_last) begin
							phase_acc_q    <= '0;
							sample_count_q <= '0;
						end else begin
							phase_acc_q    <= phase_acc_q + phase_step_q;
							sample_count_q <= sample_count_q + 16'd1;
						end
					end
					tnqm_pkg::CMD_RESTART: begin
						phase_acc_q    <= '0;
						sample_count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/tnqm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tnqm_back
// Table index, cos/sin ROM read; mix mode: complex multiply, round, saturate.
// ----------------------------------------------------------------------------
module tnqm_back #(
	parameter int TABLE_SIZE = 1024,
	parameter int AMP_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wq_empty,
	input  tnqm_pkg::work_t               wq_item,
	output logic                          wq_pop,
	input  logic [tnqm_pkg::OQ_CW-1:0]    oq_count,
	output logic                          oq_push,
	output tnqm_pkg::res_t                oq_item
);

	localparam int IW     = $clog2(TABLE_SIZE);
	localparam int PW     = 33 + IW;
	localparam int SH_UP  = (AMP_BITS < 16) ? 16 - AMP_BITS : 0;
	localparam int SH_DN  = (AMP_BITS > 16) ? AMP_BITS - 16 : 1;
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [15:0] rom_t [TABLE_SIZE];

	function automatic longint signed amp_of(input longint unsigned v);
		longint unsigned m;
		longint unsigned x;
		m = (64'd1 << (AMP_BITS - 1)) - 64'd1;
		x = ((v << (AMP_BITS - 1)) + (64'd1 << 29)) >> 30;
		if (x > m)
			x = m;
		return longint'(x);
	endfunction

	function automatic longint signed to_q15(input longint signed v);
		longint signed u;
		longint signed r;
		if (AMP_BITS == 16)
			return v;
		if (AMP_BITS < 16)
			return v * (longint'(1) << SH_UP);
		u = v + (longint'(1) << (AMP_BITS - 1));
		r = ((u + (longint'(1) << (SH_DN - 1))) >>> SH_DN) - 32768;
		if (r > 32767)
			r = 32767;
		return r;
	endfunction

	function automatic rom_t build_rom(input bit want_sin);
		rom_t              rom;
		longint unsigned   t;
		longint unsigned   r;
		longint unsigned   phi;
		longint unsigned   a;
		longint unsigned   a2;
		longint unsigned   p;
		longint unsigned   cv;
		longint unsigned   sv;
		longint signed     cp;
		longint signed     sp;
		longint signed     ce;
		longint signed     se;
		logic [1:0]        q;
		bit                sw;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			t   = (longint'(i) << 32) / TABLE_SIZE;
			q   = t[31:30];
			r   = t & (Q30_ONE - 64'd1);
			sw  = r > (Q30_ONE >> 1);
			phi = sw ? Q30_ONE - r : r;
			a   = (phi * HALF_PI_Q30) >> 30;
			a2  = (a * a) >> 30;
			p   = Q30_ONE;
			p   = Q30_ONE - ((a2 * p) >> 30) / 132;
			p   = Q30_ONE - ((a2 * p) >> 30) / 90;
			p   = Q30_ONE - ((a2 * p) >> 30) / 56;
			p   = Q30_ONE - ((a2 * p) >> 30) / 30;
			p   = Q30_ONE - ((a2 * p) >> 30) / 12;
			p   = Q30_ONE - ((a2 * p) >> 30) / 2;
			cv  = p;
			p   = Q30_ONE;
			p   = Q30_ONE - ((a2 * p) >> 30) / 110;
			p   = Q30_ONE - ((a2 * p) >> 30) / 72;
			p   = Q30_ONE - ((a2 * p) >> 30) / 42;
			p   = Q30_ONE - ((a2 * p) >> 30) / 20;
			p   = Q30_ONE - ((a2 * p) >> 30) / 6;
			sv  = (a * p) >> 30;
			cp  = amp_of(sw ? sv : cv);
			sp  = amp_of(sw ? cv : sv);
			case (q)
				2'd0: begin
					ce = cp;
					se = sp;
				end
				2'd1: begin
					ce = -sp;
					se = cp;
				end
				2'd2: begin
					ce = -cp;
					se = -sp;
				end
				default: begin
					ce = sp;
					se = -cp;
				end
			endcase
			rom[i] = 16'(to_q15(want_sin ? se : ce));
		end
		return rom;
	endfunction

	localparam rom_t COS_ROM = build_rom(1'b0);
	localparam rom_t SIN_ROM = build_rom(1'b1);

	function automatic logic signed [15:0] round_sat(input logic signed [33:0] sum);
		logic signed [33:0] rnd;
		rnd = (sum + 34'sd16384) >>> 15;
		if (rnd > 34'sd32767)
			return 16'sh7fff;
		if (rnd < -34'sd32768)
			return 16'sh8000;
		return rnd[15:0];
	endfunction

	// stage 1: table index
	logic               v_s1_q;
	logic [IW-1:0]      idx_s1;
	logic               last_s1;
	logic               mix_s1;
	logic signed [15:0] re_s1;
	logic signed [15:0] im_s1;
	// stage 2: ROM data
	logic               v_s2_q;
	logic signed [15:0] cos_s2;
	logic signed [15:0] sin_s2;
	logic               last_s2;
	logic               mix_s2;
	logic signed [15:0] re_s2;
	logic signed [15:0] im_s2;
	// stage 3: products
	logic               v_s3_q;
	logic signed [31:0] rc_s3;
	logic signed [31:0] is_s3;
	logic signed [31:0] rs_s3;
	logic signed [31:0] ic_s3;
	logic signed [15:0] cos_s3;
	logic signed [15:0] sin_s3;
	logic               last_s3;
	logic               mix_s3;

	logic [PW-1:0]             prod;
	logic [1:0]                inflight;
	logic [tnqm_pkg::OQ_CW:0]  committed;
	logic signed [33:0]        sum_re;
	logic signed [33:0]        sum_im;

	assign prod      = PW'(wq_item.phase) * PW'(TABLE_SIZE);
	assign inflight  = 2'(v_s1_q) + 2'(v_s2_q) + 2'(v_s3_q);
	assign committed = {1'b0, oq_count} + (tnqm_pkg::OQ_CW+1)'(inflight);
	assign wq_pop    = !wq_empty && (committed < (tnqm_pkg::OQ_CW+1)'(tnqm_pkg::OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			v_s1_q <= wq_pop;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= prod[32 +: IW];
		last_s1 <= wq_item.last;
		mix_s1  <= wq_item.mix;
		re_s1   <= wq_item.sample_re;
		im_s1   <= wq_item.sample_im;

		cos_s2  <= COS_ROM[idx_s1];
		sin_s2  <= SIN_ROM[idx_s1];
		last_s2 <= last_s1;
		mix_s2  <= mix_s1;
		re_s2   <= re_s1;
		im_s2   <= im_s1;

		rc_s3   <= re_s2 * cos_s2;
		is_s3   <= im_s2 * sin_s2;
		rs_s3   <= re_s2 * sin_s2;
		ic_s3   <= im_s2 * cos_s2;
		cos_s3  <= cos_s2;
		sin_s3  <= sin_s2;
		last_s3 <= last_s2;
		mix_s3  <= mix_s2;
	end

	assign sum_re = 34'(rc_s3) - 34'(is_s3);
	assign sum_im = 34'(rs_s3) + 34'(ic_s3);

	assign oq_push = v_s3_q;

	always_comb begin
		if (mix_s3) begin
			oq_item.out_re = round_sat(sum_re);
			oq_item.out_im = round_sat(sum_im);
		end else begin
			oq_item.out_re = cos_s3;
			oq_item.out_im = sin_s3;
		end
		oq_item.last = last_s3;
	end

endmodule
`default_nettype wire

[rtl/core/table_nco_quadrature_mixer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// table_nco_quadrature_mixer
// Table-driven quadrature oscillator with optional complex mixer.
// Path: command -> work queue -> index, ROM read, product stages -> result queue.
// Throughput: one command per cycle while the work queue is not full.
// Reset: control state cleared at once; tables are constant, no init pass.
// ----------------------------------------------------------------------------
module table_nco_quadrature_mixer #(
	parameter int TABLE_SIZE = 1024,
	parameter int AMP_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic [31:0]        lookup_phase,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] out_re,
	output logic signed [15:0] out_im,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic                             accept;
	logic                             wq_push;
	tnqm_pkg::work_t                  wq_in;
	tnqm_pkg::work_t                  wq_out;
	logic                             wq_pop;
	logic                             wq_empty;
	logic                             wq_full;
	logic                             oq_push;
	tnqm_pkg::res_t                   oq_in;
	tnqm_pkg::res_t                   oq_out;
	logic [tnqm_pkg::OQ_CW-1:0]       oq_count;

	assign full      = wq_full;
	assign accept    = push && !wq_full;
	assign cfg_ready = 1'b1;

	tnqm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.lookup_phase (lookup_phase),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.cfg_wr       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.wq_push      (wq_push),
		.wq_item      (wq_in)
	);

	tnqm_fifo #(
		.WIDTH ($bits(tnqm_pkg::work_t)),
		.DEPTH (tnqm_pkg::WQ_DEPTH)
	) u_work_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wq_push),
		.wr_data (wq_in),
		.rd_en   (wq_pop),
		.rd_data (wq_out),
		.empty   (wq_empty),
		.full    (wq_full),
		.count   ()
	);

	tnqm_back #(
		.TABLE_SIZE (TABLE_SIZE),
		.AMP_BITS   (AMP_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_empty (wq_empty),
		.wq_item  (wq_out),
		.wq_pop   (wq_pop),
		.oq_count (oq_count),
		.oq_push  (oq_push),
		.oq_item  (oq_in)
	);

	tnqm_fifo #(
		.WIDTH ($bits(tnqm_pkg::res_t)),
		.DEPTH (tnqm_pkg::OQ_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_push),
		.wr_data (oq_in),
		.rd_en   (pop),
		.rd_data (oq_out),
		.empty   (empty),
		.full    (),
		.count   (oq_count)
	);

	assign out_re = oq_out.out_re;
	assign out_im = oq_out.out_im;
	assign last   = oq_out.last;

endmodule
`default_nettype wire
